@@ design/md5_pkg.sv @@
// Shared types, constants and the control program of the MD5 hash engine.
// Holds the initial chaining words, round constant and rotate tables, and the microcode ROM.
// Depends on nothing; md5_seq, md5_dp and md5_hash_engine_unit import it.
`default_nettype none

package md5_pkg;

    // Default width of the message byte counter.
    localparam int unsigned CNT_BITS_DEF = 32;

    // MD5 initial chaining words.
    localparam logic [31:0] IV_A = 32'h6745_2301;
    localparam logic [31:0] IV_B = 32'hEFCD_AB89;
    localparam logic [31:0] IV_C = 32'h98BA_DCFE;
    localparam logic [31:0] IV_D = 32'h1032_5476;

    // Padding marker byte and the block position where the length field starts.
    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [5:0] LEN_POS     = 6'd56;
    localparam logic [5:0] BLK_LAST    = 6'd63;
    localparam logic [5:0] ROUND_LAST  = 6'd63;
    localparam logic [1:0] WORD_LAST   = 2'd3;

    // Datapath operations, one per control word.
    localparam logic [2:0] OP_ACCEPT = 3'd0;
    localparam logic [2:0] OP_INIT   = 3'd1;
    localparam logic [2:0] OP_ROUND  = 3'd2;
    localparam logic [2:0] OP_FINAL  = 3'd3;
    localparam logic [2:0] OP_PAD    = 3'd4;
    localparam logic [2:0] OP_CLR    = 3'd5;
    localparam logic [2:0] OP_LEN    = 3'd6;
    localparam logic [2:0] OP_EMIT   = 3'd7;

    // Sequencer jump kinds.
    localparam logic [2:0] J_ACCEPT = 3'd0;
    localparam logic [2:0] J_GOTO   = 3'd1;
    localparam logic [2:0] J_LOOP   = 3'd2;
    localparam logic [2:0] J_RET    = 3'd3;
    localparam logic [2:0] J_BRANCH = 3'd4;
    localparam logic [2:0] J_CALL   = 3'd5;
    localparam logic [2:0] J_EMIT   = 3'd6;

    // Program addresses.
    localparam logic [2:0] A_IDLE  = 3'd0;
    localparam logic [2:0] A_INIT  = 3'd1;
    localparam logic [2:0] A_ROUND = 3'd2;
    localparam logic [2:0] A_FINAL = 3'd3;
    localparam logic [2:0] A_PAD   = 3'd4;
    localparam logic [2:0] A_CLR   = 3'd5;
    localparam logic [2:0] A_LEN   = 3'd6;
    localparam logic [2:0] A_EMIT  = 3'd7;

    // One control word of the program.
    typedef struct packed {
        logic [2:0] op;
        logic [2:0] jk;
        logic [2:0] tgt;
        logic [2:0] ret;
        logic [2:0] alt;
    } ucode_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic [2:0] op;
        logic [5:0] rnd;
    } ctl_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic pos_end;
        logic pad_wide;
        logic word_last;
    } dst_t;

    // Handshake events seen by the sequencer.
    typedef struct packed {
        logic acc_fire;
        logic byte_present;
        logic eom;
        logic out_fire;
    } evt_t;

    // The program: accept bytes, compress as a subroutine, pad, append length, emit.
    function automatic ucode_t md5_ucode(input logic [2:0] addr);
        ucode_t cw;
        unique case (addr)
            A_IDLE:  cw = '{op: OP_ACCEPT, jk: J_ACCEPT, tgt: A_INIT,  ret: A_PAD,  alt: A_PAD};
            A_INIT:  cw = '{op: OP_INIT,   jk: J_GOTO,   tgt: A_ROUND, ret: A_IDLE, alt: A_IDLE};
            A_ROUND: cw = '{op: OP_ROUND,  jk: J_LOOP,   tgt: A_FINAL, ret: A_IDLE, alt: A_IDLE};
            A_FINAL: cw = '{op: OP_FINAL,  jk: J_RET,    tgt: A_IDLE,  ret: A_IDLE, alt: A_IDLE};
            A_PAD:   cw = '{op: OP_PAD,    jk: J_BRANCH, tgt: A_INIT,  ret: A_CLR,  alt: A_LEN};
            A_CLR:   cw = '{op: OP_CLR,    jk: J_GOTO,   tgt: A_LEN,   ret: A_IDLE, alt: A_IDLE};
            A_LEN:   cw = '{op: OP_LEN,    jk: J_CALL,   tgt: A_INIT,  ret: A_EMIT, alt: A_IDLE};
            A_EMIT:  cw = '{op: OP_EMIT,   jk: J_EMIT,   tgt: A_IDLE,  ret: A_IDLE, alt: A_IDLE};
            default: cw = '{op: OP_ACCEPT, jk: J_ACCEPT, tgt: A_INIT,  ret: A_PAD,  alt: A_PAD};
        endcase
        return cw;
    endfunction

    // Left rotate amount of each round.
    function automatic logic [4:0] rot_amt(input logic [5:0] r);
        logic [4:0] s;
        unique case ({r[5:4], r[1:0]})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'hA: s = 5'd16;  4'hB: s = 5'd23;
            4'hC: s = 5'd6;   4'hD: s = 5'd10;  4'hE: s = 5'd15;  4'hF: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Additive constant of each round.
    function automatic logic [31:0] round_add(input logic [5:0] r);
        logic [31:0] k;
        unique case (r)
            6'd0:  k = 32'hD76AA478; 6'd1:  k = 32'hE8C7B756; 6'd2:  k = 32'h242070DB;
            6'd3:  k = 32'hC1BDCEEE; 6'd4:  k = 32'hF57C0FAF; 6'd5:  k = 32'h4787C62A;
            6'd6:  k = 32'hA8304613; 6'd7:  k = 32'hFD469501; 6'd8:  k = 32'h698098D8;
            6'd9:  k = 32'h8B44F7AF; 6'd10: k = 32'hFFFF5BB1; 6'd11: k = 32'h895CD7BE;
            6'd12: k = 32'h6B901122; 6'd13: k = 32'hFD987193; 6'd14: k = 32'hA679438E;
            6'd15: k = 32'h49B40821; 6'd16: k = 32'hF61E2562; 6'd17: k = 32'hC040B340;
            6'd18: k = 32'h265E5A51; 6'd19: k = 32'hE9B6C7AA; 6'd20: k = 32'hD62F105D;
            6'd21: k = 32'h02441453; 6'd22: k = 32'hD8A1E681; 6'd23: k = 32'hE7D3FBC8;
            6'd24: k = 32'h21E1CDE6; 6'd25: k = 32'hC33707D6; 6'd26: k = 32'hF4D50D87;
            6'd27: k = 32'h455A14ED; 6'd28: k = 32'hA9E3E905; 6'd29: k = 32'hFCEFA3F8;
            6'd30: k = 32'h676F02D9; 6'd31: k = 32'h8D2A4C8A; 6'd32: k = 32'hFFFA3942;
            6'd33: k = 32'h8771F681; 6'd34: k = 32'h6D9D6122; 6'd35: k = 32'hFDE5380C;
            6'd36: k = 32'hA4BEEA44; 6'd37: k = 32'h4BDECFA9; 6'd38: k = 32'hF6BB4B60;
            6'd39: k = 32'hBEBFBC70; 6'd40: k = 32'h289B7EC6; 6'd41: k = 32'hEAA127FA;
            6'd42: k = 32'hD4EF3085; 6'd43: k = 32'h04881D05; 6'd44: k = 32'hD9D4D039;
            6'd45: k = 32'hE6DB99E5; 6'd46: k = 32'h1FA27CF8; 6'd47: k = 32'hC4AC5665;
            6'd48: k = 32'hF4292244; 6'd49: k = 32'h432AFF97; 6'd50: k = 32'hAB9423A7;
            6'd51: k = 32'hFC93A039; 6'd52: k = 32'h655B59C3; 6'd53: k = 32'h8F0CCC92;
            6'd54: k = 32'hFFEFF47D; 6'd55: k = 32'h85845DD1; 6'd56: k = 32'h6FA87E4F;
            6'd57: k = 32'hFE2CE6E0; 6'd58: k = 32'hA3014314; 6'd59: k = 32'h4E0811A1;
            6'd60: k = 32'hF7537E82; 6'd61: k = 32'hBD3AF235; 6'd62: k = 32'h2AD7D2BB;
            6'd63: k = 32'hEB86D391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

@@ design/md5_in_if.sv @@
// Input channel of the MD5 hash engine: one message byte with its flags per word.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface md5_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input end_of_message, output ready);
endinterface

`default_nettype wire

@@ design/md5_out_if.sv @@
// Output channel of the MD5 hash engine: one digest word per handshake.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

`default_nettype wire

@@ design/md5_seq.sv @@
// Microcode sequencer of the MD5 hash engine: program counter, return address and round counter.
// Reads the control program from md5_pkg and steers md5_dp.
`default_nettype none

module md5_seq
    import md5_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  evt_t evt,
    input  dst_t dst,
    output ctl_t ctl
);

    logic [2:0] pc_reg;
    logic [2:0] pc_next;
    logic [2:0] ret_reg;
    logic [2:0] ret_next;
    logic [5:0] rnd_reg;
    logic [5:0] rnd_next;
    ucode_t     cw;

    assign cw      = md5_ucode(pc_reg);
    assign ctl.op  = cw.op;
    assign ctl.rnd = rnd_reg;

    // Next program address from the jump kind of the current control word.
    always_comb
    begin
        pc_next  = pc_reg;
        ret_next = ret_reg;
        unique case (cw.jk)
            J_ACCEPT:
            begin
                if (evt.acc_fire)
                begin
                    // A byte that fills the block calls the compression first.
                    if (evt.byte_present && dst.pos_end)
                    begin
                        pc_next  = cw.tgt;
                        ret_next = evt.eom ? cw.ret : A_IDLE;
                    end
                    else if (evt.eom)
                    begin
                        pc_next = cw.alt;
                    end
                end
            end
            J_GOTO:
            begin
                pc_next = cw.tgt;
            end
            J_LOOP:
            begin
                if (rnd_reg == ROUND_LAST)
                begin
                    pc_next = cw.tgt;
                end
            end
            J_RET:
            begin
                pc_next = ret_reg;
            end
            J_BRANCH:
            begin
                // No room for the length field: compress, then clear a fresh block.
                if (dst.pad_wide)
                begin
                    pc_next  = cw.tgt;
                    ret_next = cw.ret;
                end
                else
                begin
                    pc_next = cw.alt;
                end
            end
            J_CALL:
            begin
                pc_next  = cw.tgt;
                ret_next = cw.ret;
            end
            J_EMIT:
            begin
                if (evt.out_fire && dst.word_last)
                begin
                    pc_next = cw.tgt;
                end
            end
            default:
            begin
                pc_next = A_IDLE;
            end
        endcase
    end

    // Round counter runs over the 64 compression rounds.
    always_comb
    begin
        rnd_next = rnd_reg;
        if (cw.op == OP_INIT)
        begin
            rnd_next = '0;
        end
        else if (cw.op == OP_ROUND)
        begin
            rnd_next = rnd_reg + 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= A_IDLE;
            ret_reg <= A_IDLE;
            rnd_reg <= '0;
        end
        else
        begin
            pc_reg  <= pc_next;
            ret_reg <= ret_next;
            rnd_reg <= rnd_next;
        end
    end

endmodule

`default_nettype wire

@@ design/md5_dp.sv @@
// Datapath of the MD5 hash engine: block words, chaining words, round registers, byte counter.
// Driven by the control from md5_seq; uses tables and types from md5_pkg.
`default_nettype none

module md5_dp
    import md5_pkg::*;
#(
    parameter int unsigned COUNT_BITS = CNT_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_t        ctl,
    input  logic        acc_fire,
    input  logic        out_fire,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    output logic [31:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word,
    output dst_t        dst
);

    logic [31:0]           blk_reg [16];
    logic [31:0]           chain_reg [4];
    logic [31:0]           va_reg;
    logic [31:0]           vb_reg;
    logic [31:0]           vc_reg;
    logic [31:0]           vd_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [1:0]            idx_reg;

    logic [5:0]  pos;
    logic [63:0] bit_len;
    logic [31:0] fn;
    logic [3:0]  sel;
    logic [31:0] sum;
    logic [63:0] rot64;
    logic [31:0] vb_next;
    logic        take_byte;

    // Write a byte into one lane, keep the lower lanes and clear the upper ones.
    function automatic logic [31:0] place_byte(input logic [31:0] old,
                                               input logic [1:0]  lane,
                                               input logic [7:0]  val);
        logic [31:0] keep;
        logic [31:0] res;
        keep = ~(32'hFFFF_FFFF << {lane, 3'b000});
        res  = (old & keep) | (32'(val) << {lane, 3'b000});
        return res;
    endfunction

    assign pos       = cnt_reg[5:0];
    assign bit_len   = 64'(cnt_reg) << 3;
    assign take_byte = acc_fire && byte_present;

    // One MD5 round: mixing function, message word select, add, rotate, add.
    always_comb
    begin
        unique case (ctl.rnd[5:4])
            2'd0:
            begin
                fn  = (vb_reg & vc_reg) | (~vb_reg & vd_reg);
                sel = ctl.rnd[3:0];
            end
            2'd1:
            begin
                fn  = (vd_reg & vb_reg) | (~vd_reg & vc_reg);
                sel = ctl.rnd[3:0] * 4'd5 + 4'd1;
            end
            2'd2:
            begin
                fn  = vb_reg ^ vc_reg ^ vd_reg;
                sel = ctl.rnd[3:0] * 4'd3 + 4'd5;
            end
            default:
            begin
                fn  = vc_reg ^ (vb_reg | ~vd_reg);
                sel = ctl.rnd[3:0] * 4'd7;
            end
        endcase
        sum     = va_reg + fn + round_add(ctl.rnd) + blk_reg[sel];
        rot64   = {sum, sum} << rot_amt(ctl.rnd);
        vb_next = vb_reg + rot64[63:32];
    end

    // Block words and working registers.
    always_ff @(posedge clk)
    begin
        unique case (ctl.op)
            OP_ACCEPT:
            begin
                if (take_byte)
                begin
                    blk_reg[pos[5:2]] <= place_byte(blk_reg[pos[5:2]], pos[1:0], data_byte);
                end
            end
            OP_INIT:
            begin
                va_reg <= chain_reg[0];
                vb_reg <= chain_reg[1];
                vc_reg <= chain_reg[2];
                vd_reg <= chain_reg[3];
            end
            OP_ROUND:
            begin
                va_reg <= vd_reg;
                vb_reg <= vb_next;
                vc_reg <= vb_reg;
                vd_reg <= vc_reg;
            end
            OP_PAD:
            begin
                // Marker byte at the current position, zeros in every word above it.
                for (int w = 0; w < 16; w++)
                begin
                    if (4'(w) > pos[5:2])
                    begin
                        blk_reg[w] <= '0;
                    end
                    else if (4'(w) == pos[5:2])
                    begin
                        blk_reg[w] <= place_byte(blk_reg[w], pos[1:0], PAD_BYTE);
                    end
                end
            end
            OP_CLR:
            begin
                for (int w = 0; w < 14; w++)
                begin
                    blk_reg[w] <= '0;
                end
            end
            OP_LEN:
            begin
                blk_reg[14] <= bit_len[31:0];
                blk_reg[15] <= bit_len[63:32];
            end
            default:
            begin
            end
        endcase
    end

    // Chaining words, byte counter and digest word index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= IV_A;
            chain_reg[1] <= IV_B;
            chain_reg[2] <= IV_C;
            chain_reg[3] <= IV_D;
            cnt_reg      <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            if (ctl.op == OP_ACCEPT && take_byte)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (ctl.op == OP_FINAL)
            begin
                chain_reg[0] <= chain_reg[0] + va_reg;
                chain_reg[1] <= chain_reg[1] + vb_reg;
                chain_reg[2] <= chain_reg[2] + vc_reg;
                chain_reg[3] <= chain_reg[3] + vd_reg;
            end
            if (ctl.op == OP_EMIT && out_fire)
            begin
                // The last digest word restarts the engine for the next message.
                if (idx_reg == WORD_LAST)
                begin
                    chain_reg[0] <= IV_A;
                    chain_reg[1] <= IV_B;
                    chain_reg[2] <= IV_C;
                    chain_reg[3] <= IV_D;
                    cnt_reg      <= '0;
                    idx_reg      <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    assign digest_word   = chain_reg[idx_reg];
    assign word_index    = idx_reg;
    assign last_word     = (idx_reg == WORD_LAST);
    assign dst.pos_end   = (pos == BLK_LAST);
    assign dst.pad_wide  = (pos >= LEN_POS);
    assign dst.word_last = (idx_reg == WORD_LAST);

endmodule

`default_nettype wire

@@ design/md5_hash_engine_unit.sv @@
// Channel   Dir  Word contents                                   Handshake
// msg       in   data_byte[7:0], byte_present, end_of_message    valid/ready
// digest    out  digest_word[31:0], word_index[1:0], last_word   valid/ready
//
// Bytes are taken one per cycle while msg.ready is high; each full 64-byte block adds a compression
// (load, 64 rounds on the single round unit, chaining add) before the next byte is taken.
// An end word adds the padding step, then, when the length field does not fit, a compression
// and a clearing step, then the length step and a compression of the last block,
// then four digest words, one per cycle while digest.ready is high.
// Reset is asynchronous and needs no clearing pass; msg.ready is low while a block
// is compressed and while digest words wait, so stalls on either side just hold the engine.
//
// Top level of the MD5 hash engine; depends on md5_pkg, md5_in_if, md5_out_if,
// md5_seq and md5_dp.
`default_nettype none

module md5_hash_engine_unit
    import md5_pkg::*;
#(
    parameter int unsigned COUNT_BITS = CNT_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    md5_in_if.sink    msg,
    md5_out_if.source digest
);

    ctl_t ctl;
    dst_t dst;
    evt_t evt;
    logic acc_fire;
    logic out_fire;

    // Handshakes follow the step the program is in.
    assign msg.ready    = (ctl.op == OP_ACCEPT);
    assign digest.valid = (ctl.op == OP_EMIT);
    assign acc_fire     = msg.valid && msg.ready;
    assign out_fire     = digest.valid && digest.ready;

    assign evt.acc_fire     = acc_fire;
    assign evt.byte_present = msg.byte_present;
    assign evt.eom          = msg.end_of_message;
    assign evt.out_fire     = out_fire;

    md5_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt),
        .dst   (dst),
        .ctl   (ctl)
    );

    md5_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .acc_fire     (acc_fire),
        .out_fire     (out_fire),
        .data_byte    (msg.data_byte),
        .byte_present (msg.byte_present),
        .digest_word  (digest.digest_word),
        .word_index   (digest.word_index),
        .last_word    (digest.last_word),
        .dst          (dst)
    );

    // The engine never takes a byte while it offers a digest word.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(msg.ready && digest.valid))
        else $error("input accepted while digest word pending");

    // An end word always starts padding or compression, never another accept.
    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (msg.valid && msg.ready && msg.end_of_message) |=> !msg.ready)
        else $error("end of message did not start processing");

    // Digest words leave in order 0 to 3.
    a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
        (digest.valid && digest.ready && !digest.last_word) |=>
            (digest.valid && digest.word_index == $past(digest.word_index) + 2'd1))
        else $error("digest word index out of order");

    // After the last digest word the engine is ready for the next message.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (digest.valid && digest.ready && digest.last_word) |=> msg.ready)
        else $error("engine did not return to accepting after the digest");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the streaming MD5 hash engine.
// Drives message words through md5_in_if, checks digest words from md5_out_if against its
// own MD5 model. Depends on md5_pkg, md5_in_if, md5_out_if and md5_hash_engine_unit.

module tb_top
    import md5_pkg::*;
();

    // One expected digest word.
    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  idx;
        logic        last;
    } digest_word_t;

    // Round constants, word 0 in the top 32 bits.
    localparam logic [64*32-1:0] ROUND_K = {
        32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
        32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
        32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
        32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
        32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
        32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
        32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
        32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
        32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
        32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
        32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
        32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
        32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
        32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
        32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
        32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
    };

    // Rotate amounts, indexed by quarter and by round modulo four, first entry on top.
    localparam logic [16*5-1:0] ROT_BY = {
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    md5_in_if  msg_if ();
    md5_out_if digest_if ();

    md5_hash_engine_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_if),
        .digest (digest_if)
    );

    // Model state: chaining words, message block and byte count.
    logic [31:0]             chain_w [4];
    logic [31:0]             msg_block [16];
    logic [CNT_BITS_DEF-1:0] byte_cnt;

    digest_word_t pending_digest_q [$];
    digest_word_t head_w;

    // Run controls and statistics.
    bit gaps_on;
    bit stalls_on;
    int hold_req;
    int msg_total;
    int data_words;
    int idle_words;
    int checked_words;
    int err_count;
    int shown;

    always #5 clk = ~clk;

    // Load the MD5 initial chaining words and restart the byte count.
    function automatic void load_iv();
        chain_w[0] = IV_A;
        chain_w[1] = IV_B;
        chain_w[2] = IV_C;
        chain_w[3] = IV_D;
        byte_cnt = '0;
    endfunction

    // Run the 64 rounds over the current block and fold into the chaining words.
    function automatic void model_compress_block();
        logic [31:0] a, b, c, d, f, t, sum;
        int unsigned g, s;
        a = chain_w[0];
        b = chain_w[1];
        c = chain_w[2];
        d = chain_w[3];
        for (int r = 0; r < 64; r++)
        begin
            case (r / 16)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = r;
                end
                1:
                begin
                    f = (d & b) | (~d & c);
                    g = (5 * r + 1) % 16;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = (3 * r + 5) % 16;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = (7 * r) % 16;
                end
            endcase
            s = ROT_BY[(15 - ((r / 16) * 4 + r % 4)) * 5 +: 5];
            sum = a + f + ROUND_K[(63 - r) * 32 +: 32] + msg_block[g];
            t = d;
            d = c;
            c = b;
            b = b + ((sum << s) | (sum >> (32 - s)));
            a = t;
        end
        chain_w[0] = chain_w[0] + a;
        chain_w[1] = chain_w[1] + b;
        chain_w[2] = chain_w[2] + c;
        chain_w[3] = chain_w[3] + d;
    endfunction

    // Put a byte into its lane; lower lanes of the word are kept, upper ones cleared.
    function automatic void place_byte(input logic [5:0] pos, input logic [7:0] val);
        logic [31:0] keep;
        int unsigned sh;
        sh = pos[1:0] * 8;
        keep = (32'd1 << sh) - 32'd1;
        msg_block[pos[5:2]] = (msg_block[pos[5:2]] & keep) | ({24'd0, val} << sh);
    endfunction

    // Advance the model by one accepted word; an end word queues the four digest words.
    function automatic void md5_take_word(input logic bp, input logic [7:0] val,
                                          input logic eom);
        logic [5:0]  pos;
        logic [63:0] bit_len;
        digest_word_t e;
        int w;
        if (bp)
        begin
            pos = byte_cnt[5:0];
            place_byte(pos, val);
            byte_cnt = byte_cnt + 1'b1;
            if (pos == BLK_LAST)
                model_compress_block();
        end
        if (eom)
        begin
            pos = byte_cnt[5:0];
            place_byte(pos, PAD_BYTE);
            for (w = pos[5:2] + 1; w < 16; w++)
                msg_block[w] = '0;
            // No room for the length field: close this block and start a fresh one.
            if (pos >= LEN_POS)
            begin
                model_compress_block();
                for (w = 0; w < 14; w++)
                    msg_block[w] = '0;
            end
            bit_len = 64'(byte_cnt) << 3;
            msg_block[14] = bit_len[31:0];
            msg_block[15] = bit_len[63:32];
            model_compress_block();
            for (w = 0; w < 4; w++)
            begin
                e.word = chain_w[w];
                e.idx  = 2'(w);
                e.last = (2'(w) == WORD_LAST);
                pending_digest_q.push_back(e);
            end
            load_iv();
        end
    endfunction

    // Offer one word, with an optional idle burst first, and wait until it is taken.
    task automatic send_word(input logic bp, input logic [7:0] val, input logic eom);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            msg_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        msg_if.valid          <= 1'b1;
        msg_if.data_byte      <= val;
        msg_if.byte_present   <= bp;
        msg_if.end_of_message <= eom;
        do
            @(posedge clk);
        while (!msg_if.ready);
        md5_take_word(bp, val, eom);
        if (bp || eom)
            data_words++;
        else
            idle_words++;
    endtask

    // Send a whole message; the last byte carries the end flag or an empty end word follows.
    task automatic send_message(input int len, input bit end_on_byte, input int noise_pct);
        bit last_one;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_word(1'b0, 8'($urandom), 1'b0);
            last_one = end_on_byte && (i == len - 1);
            send_word(1'b1, 8'($urandom), last_one);
        end
        if (!end_on_byte || len == 0)
            send_word(1'b0, 8'($urandom), 1'b1);
        msg_total++;
    endtask

    // Stop offering words until every queued digest word has arrived.
    task automatic wait_for_digests();
        msg_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_digest_q.size() != 0)
            @(posedge clk);
    endtask

    // Short fixed messages: empty, idle words, end flag with and without a byte.
    task automatic test_directed_cases();
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        send_word(1'b0, 8'hA5, 1'b1);
        send_word(1'b0, 8'hFF, 1'b0);
        send_word(1'b0, 8'h00, 1'b0);
        send_word(1'b1, 8'h61, 1'b0);
        send_word(1'b1, 8'h62, 1'b0);
        send_word(1'b1, 8'h63, 1'b1);
        send_word(1'b1, 8'h00, 1'b1);
        send_word(1'b1, 8'hFF, 1'b0);
        send_word(1'b0, 8'h00, 1'b1);
        send_word(1'b0, 8'h00, 1'b1);
        send_word(1'b0, 8'hFF, 1'b1);
        send_word(1'b1, 8'h5A, 1'b0);
        send_word(1'b0, 8'hC3, 1'b0);
        send_word(1'b1, 8'hA5, 1'b1);
        msg_total += 7;
        wait_for_digests();
    endtask

    // Short random messages with idling on both sides.
    task automatic test_random_messages();
        int len;
        bit end_on_byte;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        while (data_words < 18)
        begin
            len = $urandom_range(0, 6);
            end_on_byte = $urandom_range(0, 1);
            send_message(len, end_on_byte, 10);
            if ($urandom_range(0, 3) == 0)
                wait_for_digests();
        end
        wait_for_digests();
    endtask

    // Hold the digest side for a long stretch so the engine backs up into its input.
    // The second message ends on the byte that fills its block.
    task automatic test_digest_backpressure();
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        hold_req = 300;
        send_message(1, 1'b1, 0);
        send_message(64, 1'b1, 0);
        wait_for_digests();
    endtask

    // Back-to-back traffic with no idling on either side; the length field
    // does not fit behind the marker, so padding takes a second block.
    task automatic test_steady_stream();
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        send_message(56, 1'b1, 0);
    endtask

    // Digest side ready: long holds on request, random stall bursts otherwise.
    initial
    begin
        int hold_left;
        int stall_left;
        hold_left = 0;
        stall_left = 0;
        digest_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                digest_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                digest_if.ready <= 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 8) - 1;
                digest_if.ready <= 1'b0;
            end
            else
                digest_if.ready <= 1'b1;
        end
    end

    // Compare every digest word taken against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && digest_if.valid && digest_if.ready)
        begin
            checked_words++;
            if (pending_digest_q.size() == 0)
            begin
                err_count++;
                if (shown < 10)
                    $display("%0t: unexpected digest word %h index %0d last %b", $realtime,
                             digest_if.digest_word, digest_if.word_index, digest_if.last_word);
                shown++;
            end
            else
            begin
                head_w = pending_digest_q.pop_front();
                if (digest_if.digest_word !== head_w.word || digest_if.word_index !== head_w.idx
                    || digest_if.last_word !== head_w.last)
                begin
                    err_count++;
                    if (shown < 10)
                        $display("%0t: digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                                 $realtime, head_w.word, head_w.idx, head_w.last,
                                 digest_if.digest_word, digest_if.word_index,
                                 digest_if.last_word);
                    shown++;
                end
            end
        end
    end

    // Sequence of tests.
    initial
    begin
        msg_if.valid          <= 1'b0;
        msg_if.data_byte      <= 8'h00;
        msg_if.byte_present   <= 1'b0;
        msg_if.end_of_message <= 1'b0;
        hold_req = 0;
        load_iv();
        for (int w = 0; w < 16; w++)
            msg_block[w] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_messages();
        test_digest_backpressure();
        test_steady_stream();

        wait_for_digests();
        repeat (200) @(posedge clk);
        if (pending_digest_q.size() != 0)
            err_count++;
        $display("Covered %0d messages: %0d data words and %0d idle words sent.",
                 msg_total, data_words, idle_words);
        $display("Checked %0d digest words under random stalls and a long hold, %0d errors.",
                 checked_words, err_count);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d digest words still expected.", pending_digest_q.size());
        $display("status: fail");
        $finish;
    end

endmodule
